FILE: hdl/rtn_pkg.sv
// Shared types, codes and the step decoder of the segment/triangle nearest-hit block.
// Used by rtn_mac and ray_triangle_nearest_hit; depends on nothing.
package rtn_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int INDEX_BITS_DEF = 16;

	// configuration register indexes
	localparam logic [2:0] REG_START_X = 3'd0;
	localparam logic [2:0] REG_START_Y = 3'd1;
	localparam logic [2:0] REG_START_Z = 3'd2;
	localparam logic [2:0] REG_END_X   = 3'd3;
	localparam logic [2:0] REG_END_Y   = 3'd4;
	localparam logic [2:0] REG_END_Z   = 3'd5;

	localparam int STEP_BITS = 5;
	localparam logic [STEP_BITS-1:0] STEP_NDEN    = 5'd6;
	localparam logic [STEP_BITS-1:0] STEP_NNUM    = 5'd9;
	localparam logic [STEP_BITS-1:0] STEP_NUM_END = 5'd11;
	localparam logic [STEP_BITS-1:0] STEP_PT      = 5'd12;
	localparam logic [STEP_BITS-1:0] STEP_EDGE    = 5'd15;
	localparam logic [STEP_BITS-1:0] STEP_EDOT    = 5'd21;
	localparam logic [STEP_BITS-1:0] STEP_DIST    = 5'd24;
	localparam logic [STEP_BITS-1:0] STEP_MAX     = 5'd26;

	typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_CHK, S_DIVW, S_FIN} state_t;
	typedef enum logic [3:0] {K_E1, K_E2, K_N, K_DIR, K_W, K_TQ, K_PW, K_C, K_PS} kind_t;
	typedef enum logic [1:0] {INIT_KEEP, INIT_ZERO, INIT_HALF} init_t;
	typedef enum logic [2:0] {DST_NONE, DST_N, DST_DEN, DST_NUM, DST_P, DST_C, DST_EDGE,
		DST_DIST} dst_t;

	typedef struct packed {
		kind_t      a_kind;
		logic [1:0] a_ax;
		kind_t      b_kind;
		logic [1:0] b_ax;
		init_t      init;
		logic       neg;
		dst_t       dst;
		logic [1:0] d_ax;
	} ctl_t;

	typedef struct packed {
		logic  go;
		init_t init;
		logic  neg;
	} mac_req_t;

	function automatic logic [1:0] nxt(input logic [1:0] ax);
		return (ax == 2'd2) ? 2'd0 : ax + 2'd1;
	endfunction

	// One multiply-accumulate per step.
	function automatic ctl_t step_ctl(input logic [STEP_BITS-1:0] st);
		ctl_t c;
		logic [STEP_BITS-1:0] t;
		logic [1:0] k;
		c.a_kind = K_E1;
		c.a_ax   = 2'd0;
		c.b_kind = K_E2;
		c.b_ax   = 2'd0;
		c.init   = INIT_KEEP;
		c.neg    = 1'b0;
		c.dst    = DST_NONE;
		c.d_ax   = 2'd0;
		if (st < STEP_NDEN || (st >= STEP_EDGE && st < STEP_EDOT)) begin
			// cross product, two products per component
			t = (st < STEP_NDEN) ? st : st - STEP_EDGE;
			k = t[2:1];
			c.b_kind = (st < STEP_NDEN) ? K_E2 : K_PW;
			c.d_ax = k;
			if (!t[0]) begin
				c.a_ax = nxt(k);
				c.b_ax = nxt(nxt(k));
				c.init = INIT_ZERO;
			end else begin
				c.a_ax = nxt(nxt(k));
				c.b_ax = nxt(k);
				c.neg  = 1'b1;
				c.dst  = (st < STEP_NDEN) ? DST_N : DST_C;
			end
		end else if (st < STEP_PT) begin
			t = (st < STEP_NNUM) ? st - STEP_NDEN : st - STEP_NNUM;
			c.a_kind = K_N;
			c.a_ax   = t[1:0];
			c.b_kind = (st < STEP_NNUM) ? K_DIR : K_W;
			c.b_ax   = t[1:0];
			c.init   = (t == '0) ? INIT_ZERO : INIT_KEEP;
			if (t[1]) c.dst = (st < STEP_NNUM) ? DST_DEN : DST_NUM;
		end else if (st < STEP_EDGE) begin
			t = st - STEP_PT;
			c.a_kind = K_DIR;
			c.a_ax   = t[1:0];
			c.b_kind = K_TQ;
			c.init   = INIT_HALF;
			c.dst    = DST_P;
			c.d_ax   = t[1:0];
		end else if (st < STEP_DIST) begin
			t = st - STEP_EDOT;
			c.a_kind = K_N;
			c.a_ax   = t[1:0];
			c.b_kind = K_C;
			c.b_ax   = t[1:0];
			c.init   = (t == '0) ? INIT_ZERO : INIT_KEEP;
			if (t[1]) c.dst = DST_EDGE;
		end else begin
			t = st - STEP_DIST;
			c.a_kind = K_PS;
			c.a_ax   = t[1:0];
			c.b_kind = K_PS;
			c.b_ax   = t[1:0];
			c.init   = (t == '0) ? INIT_ZERO : INIT_KEEP;
			if (t[1]) c.dst = DST_DIST;
		end
		return c;
	endfunction

endpackage

FILE: hdl/ray_triangle_nearest_hit.sv
// Top level of the segment/triangle nearest-hit block: sequencer, operand select, state.
// Depends on rtn_pkg, rtn_mac and rtn_div.
//
// Usage: write the segment start and end (indexes 0..5) over the cfg channel while idle;
// cfg_ready is always high. Then send triangles on the in channel, one word per triangle,
// with last_triangle set on the final one of a mesh. A word is taken when in_valid is high
// and in_stall is low; in_stall stays high while a triangle is being processed.
// All arithmetic runs through one serial multiply-accumulate unit, one multiplier bit per
// cycle, over 2*COORD_BITS+3 bits. A triangle that hits takes 45 product steps plus a serial
// divide; one rejected at the plane test takes 12 steps, one rejected at an edge between
// 24 and 42 steps.
// On the last triangle one result word appears on the out channel in the cycle after its
// processing ends, and the nearest-hit state clears. The result sits in an output
// register: if the receiver holds out_stall, the next mesh may already start, and only
// the next last triangle waits for the register to empty.
// Reset clears the segment registers to zero, the best distance to all ones, and the
// triangle counter.
module ray_triangle_nearest_hit import rtn_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] vertex0_x,
	input  logic signed [COORD_BITS-1:0] vertex0_y,
	input  logic signed [COORD_BITS-1:0] vertex0_z,
	input  logic signed [COORD_BITS-1:0] vertex1_x,
	input  logic signed [COORD_BITS-1:0] vertex1_y,
	input  logic signed [COORD_BITS-1:0] vertex1_z,
	input  logic signed [COORD_BITS-1:0] vertex2_x,
	input  logic signed [COORD_BITS-1:0] vertex2_y,
	input  logic signed [COORD_BITS-1:0] vertex2_z,
	input  logic                         last_triangle,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         any_hit,
	output logic signed [COORD_BITS-1:0] hit_x,
	output logic signed [COORD_BITS-1:0] hit_y,
	output logic signed [COORD_BITS-1:0] hit_z,
	output logic [INDEX_BITS-1:0]        nearest_index
);
	localparam int CB  = COORD_BITS;
	localparam int DB  = CB + 1;          // coordinate differences
	localparam int NB  = 2 * DB + 1;      // normal and edge cross products
	localparam int QB  = 3 * DB + 3;      // plane numerator and denominator
	localparam int AB  = 2 * NB + 2;      // accumulator
	localparam int TF  = CB + 2;          // fraction bits of t
	localparam int TQB = TF + 1;
	localparam int DSB = 2 * CB + 2;      // squared distance

	state_t state_q, state_n;
	ctl_t ctl;
	mac_req_t mac_req;
	logic mac_busy, div_busy, div_go;
	logic signed [AB-1:0] acc;
	logic [TQB-1:0] div_quo;

	logic signed [CB-1:0] start_q [3];
	logic signed [CB-1:0] end_q [3];
	logic signed [CB-1:0] v0_q [3];
	logic signed [CB-1:0] v1_q [3];
	logic signed [CB-1:0] v2_q [3];
	logic signed [CB-1:0] p_q [3];
	logic signed [NB-1:0] n_q [3];
	logic signed [NB-1:0] c_q [3];
	logic signed [QB-1:0] num_q, den_q;
	logic [TQB-1:0] tq_q;
	logic [STEP_BITS-1:0] step_q;
	logic [1:0] eg_q;
	logic last_q, hit_q;

	logic [DSB-1:0] best_dist_q;
	logic signed [CB-1:0] best_x_q, best_y_q, best_z_q;
	logic [INDEX_BITS-1:0] best_idx_q, tri_cnt_q;
	logic hit_seen_q;

	logic signed [DB-1:0] dir [3];
	logic signed [DB-1:0] e1 [3];
	logic signed [DB-1:0] e2 [3];
	logic signed [DB-1:0] w [3];
	logic signed [DB-1:0] pw [3];
	logic signed [DB-1:0] ps [3];
	logic signed [NB-1:0] op_a, op_b;

	logic signed [QB-1:0] dmag, nsgn;
	logic plane_miss, fin_go, closer;
	logic [DSB-1:0] cand_dist;

	function automatic logic signed [NB-1:0] xd(input logic signed [DB-1:0] x);
		return {{(NB-DB){x[DB-1]}}, x};
	endfunction

	// v0 - v1 - v2 rotate during the edge loop, so the edge under test is v0 -> v1
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dir[k] = {end_q[k][CB-1], end_q[k]} - {start_q[k][CB-1], start_q[k]};
			e1[k]  = {v1_q[k][CB-1], v1_q[k]} - {v0_q[k][CB-1], v0_q[k]};
			e2[k]  = {v2_q[k][CB-1], v2_q[k]} - {v0_q[k][CB-1], v0_q[k]};
			w[k]   = {v0_q[k][CB-1], v0_q[k]} - {start_q[k][CB-1], start_q[k]};
			pw[k]  = {p_q[k][CB-1], p_q[k]} - {v0_q[k][CB-1], v0_q[k]};
			ps[k]  = {p_q[k][CB-1], p_q[k]} - {start_q[k][CB-1], start_q[k]};
		end
	end

	assign ctl = step_ctl(step_q);

	always_comb begin
		case (ctl.a_kind)
			K_N:     op_a = n_q[ctl.a_ax];
			K_DIR:   op_a = xd(dir[ctl.a_ax]);
			K_PS:    op_a = xd(ps[ctl.a_ax]);
			default: op_a = xd(e1[ctl.a_ax]);
		endcase
		case (ctl.b_kind)
			K_DIR:   op_b = xd(dir[ctl.b_ax]);
			K_W:     op_b = xd(w[ctl.b_ax]);
			K_TQ:    op_b = {{(NB-TQB){1'b0}}, tq_q};
			K_PW:    op_b = xd(pw[ctl.b_ax]);
			K_C:     op_b = c_q[ctl.b_ax];
			K_PS:    op_b = xd(ps[ctl.b_ax]);
			default: op_b = xd(e2[ctl.b_ax]);
		endcase
	end

	// Plane test: flip signs so the denominator is positive, then 0 <= numer <= denom.
	always_comb begin
		dmag = den_q[QB-1] ? -den_q : den_q;
		nsgn = den_q[QB-1] ? -num_q : num_q;
		plane_miss = (den_q == '0) || nsgn[QB-1] || ($unsigned(nsgn) > $unsigned(dmag));
	end

	assign cand_dist = acc[DSB-1:0];
	assign closer    = hit_q && (cand_dist < best_dist_q);
	assign fin_go    = !last_q || !out_valid || !out_stall;

	assign mac_req.go   = (state_q == S_ISSUE);
	assign mac_req.init = ctl.init;
	assign mac_req.neg  = ctl.neg;
	assign div_go       = (state_q == S_CHK) && !plane_miss;
	assign in_stall     = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;

	rtn_mac #(.NB(NB), .AB(AB), .TF(TF)) u_mac (
		.clk(clk), .arst_n(arst_n), .req(mac_req), .a(op_a), .b(op_b),
		.acc(acc), .busy(mac_busy)
	);

	rtn_div #(.QB(QB), .TQB(TQB)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(nsgn), .den(dmag),
		.quo(div_quo), .busy(div_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_n = S_ISSUE;
			S_ISSUE: state_n = S_WAIT;
			S_WAIT: begin
				if (!mac_busy) begin
					unique case (ctl.dst)
						DST_NUM:  state_n = S_CHK;
						DST_EDGE: state_n = acc[AB-1] ? S_FIN : S_ISSUE;
						DST_DIST: state_n = S_FIN;
						default:  state_n = S_ISSUE;
					endcase
				end
			end
			S_CHK:   state_n = plane_miss ? S_FIN : S_DIVW;
			S_DIVW:  if (!div_busy) state_n = S_ISSUE;
			S_FIN:   if (fin_go) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				start_q[k] <= '0;
				end_q[k]   <= '0;
			end
			step_q      <= '0;
			eg_q        <= '0;
			hit_q       <= 1'b0;
			last_q      <= 1'b0;
			best_dist_q <= '1;
			best_x_q    <= '0;
			best_y_q    <= '0;
			best_z_q    <= '0;
			best_idx_q  <= '0;
			hit_seen_q  <= 1'b0;
			tri_cnt_q   <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_START_X: start_q[0] <= cfg_data;
					REG_START_Y: start_q[1] <= cfg_data;
					REG_START_Z: start_q[2] <= cfg_data;
					REG_END_X:   end_q[0]   <= cfg_data;
					REG_END_Y:   end_q[1]   <= cfg_data;
					REG_END_Z:   end_q[2]   <= cfg_data;
					default:     ;
				endcase
			end
			if (out_valid && !out_stall && !(state_q == S_FIN && fin_go && last_q))
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= last_triangle;
						step_q <= '0;
						eg_q   <= '0;
						hit_q  <= 1'b0;
					end
				end
				S_WAIT: begin
					if (!mac_busy) begin
						if (ctl.dst == DST_EDGE) begin
							// advance to the next edge, or on to the distance
							if (eg_q == 2'd2) begin
								eg_q   <= '0;
								step_q <= STEP_DIST;
							end else begin
								eg_q   <= eg_q + 2'd1;
								step_q <= STEP_EDGE;
							end
						end else if (ctl.dst == DST_DIST) begin
							hit_q <= 1'b1;
						end else if (ctl.dst != DST_NUM) begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				S_DIVW: if (!div_busy) step_q <= STEP_PT;
				S_FIN: begin
					if (fin_go) begin
						if (last_q) begin
							// hand over the result and drop back to the reset state
							out_valid     <= 1'b1;
							any_hit       <= hit_seen_q | hit_q;
							hit_x         <= closer ? p_q[0] : best_x_q;
							hit_y         <= closer ? p_q[1] : best_y_q;
							hit_z         <= closer ? p_q[2] : best_z_q;
							nearest_index <= closer ? tri_cnt_q : best_idx_q;
							best_dist_q   <= '1;
							best_x_q      <= '0;
							best_y_q      <= '0;
							best_z_q      <= '0;
							best_idx_q    <= '0;
							hit_seen_q    <= 1'b0;
							tri_cnt_q     <= '0;
						end else begin
							tri_cnt_q  <= tri_cnt_q + 1'b1;
							hit_seen_q <= hit_seen_q | hit_q;
							if (closer) begin
								best_dist_q <= cand_dist;
								best_x_q    <= p_q[0];
								best_y_q    <= p_q[1];
								best_z_q    <= p_q[2];
								best_idx_q  <= tri_cnt_q;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					v0_q[0] <= vertex0_x; v0_q[1] <= vertex0_y; v0_q[2] <= vertex0_z;
					v1_q[0] <= vertex1_x; v1_q[1] <= vertex1_y; v1_q[2] <= vertex1_z;
					v2_q[0] <= vertex2_x; v2_q[1] <= vertex2_y; v2_q[2] <= vertex2_z;
				end
			end
			S_WAIT: begin
				if (!mac_busy) begin
					case (ctl.dst)
						DST_N:   n_q[ctl.d_ax] <= acc[NB-1:0];
						DST_C:   c_q[ctl.d_ax] <= acc[NB-1:0];
						DST_DEN: den_q <= acc[QB-1:0];
						DST_NUM: num_q <= acc[QB-1:0];
						DST_P:   p_q[ctl.d_ax] <= start_q[ctl.d_ax] + acc[TF +: CB];
						DST_EDGE: begin
							for (int k = 0; k < 3; k++) begin
								v0_q[k] <= v1_q[k];
								v1_q[k] <= v2_q[k];
								v2_q[k] <= v0_q[k];
							end
						end
						default: ;
					endcase
				end
			end
			S_DIVW: if (!div_busy) tq_q <= div_quo;
			default: ;
		endcase
	end

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mac_busy && div_busy)) else $error("mac and divider busy together");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mac_req.go |-> (!mac_busy && !div_busy)) else $error("mac started while busy");
	a_best_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!hit_seen_q |-> (best_dist_q == {DSB{1'b1}})) else $error("best distance without hit");
	a_chk_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> (step_q == STEP_NUM_END)) else $error("plane check off step");
endmodule

FILE: hdl/rtn_mac.sv
// Serial signed multiply-accumulate, one multiplier bit per cycle.
// Depends on rtn_pkg (mac_req_t, init_t).
module rtn_mac import rtn_pkg::*; #(
	parameter int NB = 51,
	parameter int AB = 104,
	parameter int TF = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mac_req_t             req,
	input  logic signed [NB-1:0] a,
	input  logic signed [NB-1:0] b,
	output logic signed [AB-1:0] acc,
	output logic                 busy
);
	localparam int CNTB = $clog2(NB);
	localparam logic [AB-1:0] HALF = {{(AB-1){1'b0}}, 1'b1} << (TF - 1);

	logic signed [AB-1:0] a_q, acc_q;
	logic [NB-1:0] b_q;
	logic [CNTB-1:0] cnt_q;
	logic busy_q, neg_q, sub;

	// the sign bit of b carries negative weight
	assign sub = neg_q ^ (cnt_q == CNTB'(NB - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTB'(NB - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q   <= {{(AB-NB){a[NB-1]}}, a};
			b_q   <= b;
			neg_q <= req.neg;
			case (req.init)
				INIT_ZERO: acc_q <= '0;
				INIT_HALF: acc_q <= HALF;
				default:   acc_q <= acc_q;
			endcase
		end else if (busy_q) begin
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
			if (b_q[0]) acc_q <= sub ? acc_q - a_q : acc_q + a_q;
		end
	end

	assign acc  = acc_q;
	assign busy = busy_q;
endmodule

FILE: hdl/rtn_div.sv
// Restoring divider, one quotient bit per cycle, for numerator no larger than denominator.
// Standalone; no package items used.
module rtn_div #(
	parameter int QB  = 78,
	parameter int TQB = 27
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [QB-1:0]  num,
	input  logic [QB-1:0]  den,
	output logic [TQB-1:0] quo,
	output logic           busy
);
	localparam int CNTB = $clog2(TQB);

	logic [QB:0] r_q, rs;
	logic [QB-1:0] d_q;
	logic [TQB-1:0] q_q;
	logic [CNTB-1:0] cnt_q;
	logic busy_q, ge;
	logic [QB+1:0] diff;

	always_comb begin
		rs   = (cnt_q == '0) ? r_q : {r_q[QB-1:0], 1'b0};
		diff = {1'b0, rs} - {2'b00, d_q};
		ge   = !diff[QB+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTB'(TQB - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			r_q <= {1'b0, num};
			d_q <= den;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? diff[QB:0] : rs;
			q_q <= {q_q[TQB-2:0], ge};
		end
	end

	assign quo  = q_q;
	assign busy = busy_q;
endmodule
